FILE: rtl/core/kwc_pkg.sv
// ----------------------------------------------------------------------------
// kwc_pkg
// Shared types and constants of the keyword occurrence counter: register
// codes, key byte layout and default sizes.
// ----------------------------------------------------------------------------
package kwc_pkg;

    // default sizes handed to the top level parameters
    localparam int KEY_MAX_DEF    = 16;
    localparam int COUNT_BITS_DEF = 32;

    // fixed field widths
    localparam int KEY_BYTES   = 16;
    localparam int KEY_IDX_W   = 4;
    localparam int KEY_LEN_W   = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int OUT_COUNT_W = 32;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LOW    = 2'd0,
        REG_KEY_HIGH   = 2'd1,
        REG_KEY_LENGTH = 2'd2
    } cfg_reg_t;

    // key bytes, byte 0 is the first byte of the keyword
    typedef logic [KEY_BYTES-1:0][7:0] key_bytes_t;

    // key setup seen by the scan logic
    typedef struct packed {
        key_bytes_t           key;
        logic [KEY_LEN_W-1:0] length;   // already clamped to 1..KEY_MAX
    } key_cfg_t;

endpackage

FILE: rtl/core/kwc_in_if.sv
// ----------------------------------------------------------------------------
// kwc_in_if
// Byte channel into the counter: one file byte and its framing per
// transaction.
// ----------------------------------------------------------------------------
interface kwc_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_file;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_file, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_file, output ready);
    modport monitor (input valid, input data_byte, input byte_present,
                     input end_of_file, input ready);

endinterface

FILE: rtl/core/kwc_out_if.sv
// ----------------------------------------------------------------------------
// kwc_out_if
// Result channel of the counter: one occurrence count per file.
// ----------------------------------------------------------------------------
interface kwc_out_if;

    logic        valid;
    logic        ready;
    logic [31:0] occurrence_count;

    modport source  (output valid, output occurrence_count, input ready);
    modport sink    (input valid, input occurrence_count, output ready);
    modport monitor (input valid, input occurrence_count, input ready);

endinterface

FILE: rtl/core/keyword_occurrence_counter.sv
// ----------------------------------------------------------------------------
// keyword_occurrence_counter
// Counts non-overlapping occurrences of a 1 to 16 byte keyword in a byte
// stream and returns the count at each end-of-file marker.
// ----------------------------------------------------------------------------
// The block takes one byte transaction per clock cycle and keeps that rate as
// long as results are taken: the window compare, the block countdown and the
// saturating count update all sit between the input register and the state
// registers, so a new byte enters every cycle. The count of a file passes
// through the input register and the result register to the result channel.
// The byte channel stalls only while a finished count waits in the result
// register and a further end-of-file transaction is next in line; bytes of
// the following file keep flowing. Write the key registers only while no
// file is in flight; a key length of 0 acts as 1, any above KEY_MAX acts as
// KEY_MAX. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module keyword_occurrence_counter
    import kwc_pkg::*;
#(
    parameter int KEY_MAX    = KEY_MAX_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    kwc_in_if.sink                item,
    kwc_out_if.source             result
);

    key_cfg_t key_cfg;

    // keyword registers
    kwc_cfg_regs #(
        .KEY_MAX   (KEY_MAX)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_cfg   (key_cfg)
    );

    // scan datapath
    kwc_scan #(
        .KEY_MAX    (KEY_MAX),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_cfg (key_cfg),
        .item    (item),
        .result  (result)
    );

endmodule

FILE: rtl/core/kwc_cfg_regs.sv
// ----------------------------------------------------------------------------
// kwc_cfg_regs
// Keyword configuration registers with the write port, and clamping of the
// key length to the supported range.
// ----------------------------------------------------------------------------
module kwc_cfg_regs
    import kwc_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output key_cfg_t              key_cfg
);

    logic [CFG_DATA_W-1:0] key_low_reg;
    logic [CFG_DATA_W-1:0] key_high_reg;
    logic [KEY_LEN_W-1:0]  key_length_reg;
    logic [KEY_LEN_W-1:0]  length_clamped;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= KEY_LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_LOW:    key_low_reg    <= cfg_data;
                REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // zero acts as one, anything above the window depth acts as the depth
    always_comb
    begin
        if (key_length_reg == '0)
            length_clamped = KEY_LEN_W'(1);
        else if (key_length_reg > KEY_LEN_W'(KEY_MAX))
            length_clamped = KEY_LEN_W'(KEY_MAX);
        else
            length_clamped = key_length_reg;
    end

    assign key_cfg.key    = {key_high_reg, key_low_reg};
    assign key_cfg.length = length_clamped;

endmodule

FILE: rtl/core/kwc_match.sv
// ----------------------------------------------------------------------------
// kwc_match
// Window compare: checks the newest key-length bytes of the window against
// the keyword, one byte lane per window position.
// ----------------------------------------------------------------------------
module kwc_match
    import kwc_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF,
    parameter int LEN_W   = $clog2(KEY_MAX + 1)
) (
    input  logic [KEY_MAX-1:0][7:0] window,     // entry 0 is the newest byte
    input  key_bytes_t              key,
    input  logic [LEN_W-1:0]        key_len,
    output logic                    hit
);

    logic [KEY_MAX-1:0] lane_ok;

    // window entry k lines up with key byte len-1-k
    for (genvar k = 0; k < KEY_MAX; k++)
    begin : g_lane
        logic                 in_use;
        logic [KEY_IDX_W-1:0] key_idx;

        assign in_use     = LEN_W'(k) < key_len;
        assign key_idx    = KEY_IDX_W'(key_len - LEN_W'(1) - LEN_W'(k));
        assign lane_ok[k] = !in_use || (window[k] == key[key_idx]);
    end

    assign hit = &lane_ok;

endmodule

FILE: rtl/core/kwc_scan.sv
// ----------------------------------------------------------------------------
// kwc_scan
// Input register, per-file scan state (byte window, fill, block, count) and
// the result register with its handshake.
// ----------------------------------------------------------------------------
module kwc_scan
    import kwc_pkg::*;
#(
    parameter int KEY_MAX    = KEY_MAX_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  key_cfg_t  key_cfg,
    kwc_in_if.sink    item,
    kwc_out_if.source result
);

    localparam int LEN_W = $clog2(KEY_MAX + 1);
    localparam int BLK_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_eof_reg;

    // per-file state
    logic [KEY_MAX-1:0][7:0] window_reg;
    logic [KEY_MAX-1:0][7:0] window_next;
    logic [LEN_W-1:0]        fill_reg;
    logic [LEN_W-1:0]        fill_next;
    logic [BLK_W-1:0]        blocked_reg;
    logic [BLK_W-1:0]        blocked_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;

    // result register
    logic                   out_valid_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;

    logic             slot_free;
    logic             proc;
    logic             take;
    logic [LEN_W-1:0] key_len;
    logic             hit;
    logic             match_found;

    assign key_len = LEN_W'(key_cfg.length);

    // an item without end marker never waits for the result slot
    assign slot_free  = !out_valid_reg || result.ready;
    assign proc       = in_valid_reg && (!in_eof_reg || slot_free);
    assign item.ready = !in_valid_reg || proc;
    assign take       = item.valid && item.ready;

    // window with the new byte shifted in
    always_comb
    begin
        for (int i = KEY_MAX - 1; i > 0; i--)
            window_next[i] = window_reg[i-1];
        window_next[0] = in_byte_reg;
    end

    kwc_match #(
        .KEY_MAX (KEY_MAX),
        .LEN_W   (LEN_W)
    ) u_match (
        .window  (window_next),
        .key     (key_cfg.key),
        .key_len (key_len),
        .hit     (hit)
    );

    // fill, block and count after this byte
    always_comb
    begin
        fill_next    = fill_reg;
        blocked_next = blocked_reg;
        count_next   = count_reg;
        match_found  = 1'b0;
        if (in_present_reg)
        begin
            if (fill_reg != LEN_W'(KEY_MAX))
                fill_next = fill_reg + LEN_W'(1);
            if (blocked_reg != '0)
                blocked_next = blocked_reg - BLK_W'(1);
            else if (fill_next >= key_len && hit)
                match_found = 1'b1;
        end
        if (match_found)
        begin
            blocked_next = BLK_W'(key_len - LEN_W'(1));
            if (count_reg != '1)
                count_next = count_reg + COUNT_BITS'(1);
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg    <= item.data_byte;
            in_present_reg <= item.byte_present;
            in_eof_reg     <= item.end_of_file;
        end
    end

    // window holds payload only: the fill count masks stale bytes
    always_ff @(posedge clk)
    begin
        if (proc && in_present_reg)
            window_reg <= window_next;
    end

    // per-file state, cleared after the end marker
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            blocked_reg <= '0;
            count_reg   <= '0;
        end
        else if (proc)
        begin
            if (in_eof_reg)
            begin
                fill_reg    <= '0;
                blocked_reg <= '0;
                count_reg   <= '0;
            end
            else
            begin
                fill_reg    <= fill_next;
                blocked_reg <= blocked_next;
                count_reg   <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc && in_eof_reg)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_eof_reg)
            out_count_reg <= OUT_COUNT_W'(count_next);
    end

    assign result.valid            = out_valid_reg;
    assign result.occurrence_count = out_count_reg;

endmodule

FILE: rtl/core/kwc_checker.sv
// ----------------------------------------------------------------------------
// kwc_checker
// Port-level checks of the keyword occurrence counter, bound to the top
// level.
// ----------------------------------------------------------------------------
module kwc_checker (
    input logic       clk,
    input logic       rst_n,
    kwc_in_if.sink    item,
    kwc_out_if.source result
);

    // a pending count stays offered until taken
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid
    ) else $error("result valid dropped before transaction");

    // a pending count does not change while stalled
    a_result_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> $stable(result.occurrence_count)
    ) else $error("result count changed while stalled");

    // byte channel only backs up behind a stalled result
    a_stall_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item.ready |-> result.valid && !result.ready
    ) else $error("byte channel stalled without a stalled result");

endmodule

bind keyword_occurrence_counter kwc_checker u_kwc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .result (result)
);
